>>> src/skwst_pkg.sv
`timescale 1ns / 1ps
package skwst_pkg;

  localparam int VERTEX_BITS   = 12;
  localparam int VERTEX_COUNT  = 1 << VERTEX_BITS;
  localparam int BONE_BITS     = 8;
  localparam int WEIGHT_BITS   = 16;
  localparam int SLOT_COUNT    = 4;
  localparam int SLOT_BITS     = 2;
  localparam int SUM_BITS      = 40;
  localparam int COUNT_BITS    = 24;
  localparam int QUO_BITS      = 16;
  localparam int LANES         = SLOT_COUNT + 1;
  localparam int SLOT_SUM_BITS = WEIGHT_BITS + SLOT_BITS;
  localparam int DIV_CNT_BITS  = $clog2(QUO_BITS);

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef struct packed {
    action_t                op;
    logic [VERTEX_BITS-1:0] vertex;
    logic [BONE_BITS-1:0]   bone;
    logic [WEIGHT_BITS-1:0] weight;
  } item_t;

  typedef struct packed {
    logic                                  accepted;
    logic [SLOT_BITS-1:0]                  slot;
    logic [SLOT_COUNT-1:0][BONE_BITS-1:0]  bones;
    logic [SLOT_COUNT-1:0][QUO_BITS-1:0]   norms;
    logic [QUO_BITS-1:0]                   mean;
    logic [BONE_BITS-1:0]                  last_bone;
  } res_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

>>> src/skin_weight_slot_table_top.sv
`timescale 1ns / 1ps
// channel | direction | handshake             | payload
// in_     | input     | in_valid / in_ready   | action, vertex, bone, weight
// out_    | output    | out_valid / out_ready | accepted, slot, bones, norm weights,
//         |           |                       | mean_weight, last_bone
//
// add, read and no-op transactions pass through the back end as queue pop, store read,
// the five restoring divider lanes working through 16 quotient bits, result load
// clear also sweeps all 4096 store entries, one store entry zeroed per cycle
// after reset the same sweep over all store entries runs and in_ready stays low until it ends
// a two-entry queue takes input while the back end works or a result waits on out_ready
module skin_weight_slot_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [11:0] in_vertex,
  input  logic [7:0]  in_bone,
  input  logic [15:0] in_weight,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic [1:0]  out_slot,
  output logic [7:0]  out_bone_a,
  output logic [7:0]  out_bone_b,
  output logic [7:0]  out_bone_c,
  output logic [7:0]  out_bone_d,
  output logic [15:0] out_norm_weight_a,
  output logic [15:0] out_norm_weight_b,
  output logic [15:0] out_norm_weight_c,
  output logic [15:0] out_norm_weight_d,
  output logic [15:0] out_mean_weight,
  output logic [7:0]  out_last_bone
);

  skwst_pkg::queue_head_t head;
  skwst_pkg::res_t        res;
  logic                   head_pop;
  logic                   init_busy;

  // front end: input queue and action decode
  skwst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .in_vertex (in_vertex),
    .in_bone   (in_bone),
    .in_weight (in_weight),
    .init_busy (init_busy),
    .head      (head),
    .head_pop  (head_pop)
  );

  // back end: slot store, running totals, dividers, result register
  skwst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_pop  (head_pop),
    .init_busy (init_busy),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  // slot 0 is the lowest index in the packed arrays
  assign out_accepted      = res.accepted;
  assign out_slot          = res.slot;
  assign out_bone_a        = res.bones[0];
  assign out_bone_b        = res.bones[1];
  assign out_bone_c        = res.bones[2];
  assign out_bone_d        = res.bones[3];
  assign out_norm_weight_a = res.norms[0];
  assign out_norm_weight_b = res.norms[1];
  assign out_norm_weight_c = res.norms[2];
  assign out_norm_weight_d = res.norms[3];
  assign out_mean_weight   = res.mean;
  assign out_last_bone     = res.last_bone;

endmodule

>>> src/skwst_front.sv
`timescale 1ns / 1ps
module skwst_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_action,
  input  logic [11:0]           in_vertex,
  input  logic [7:0]            in_bone,
  input  logic [15:0]           in_weight,
  input  logic                  init_busy,
  output skwst_pkg::queue_head_t head,
  input  logic                  head_pop
);

  // two-entry queue between the input port and the back end
  skwst_pkg::item_t q_mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready  = (cnt_r != 2'd2) && !init_busy;
  assign push      = in_valid && in_ready;
  assign pop       = head.valid && head_pop;
  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r].op     <= skwst_pkg::action_t'(in_action);
      q_mem[wr_ptr_r].vertex <= in_vertex;
      q_mem[wr_ptr_r].bone   <= in_bone;
      q_mem[wr_ptr_r].weight <= in_weight;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

>>> src/skwst_back.sv
`timescale 1ns / 1ps
module skwst_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  skwst_pkg::queue_head_t head,
  output logic                   head_pop,
  output logic                   init_busy,
  output logic                   res_valid,
  input  logic                   res_ready,
  output skwst_pkg::res_t        res
);

  localparam int VB = skwst_pkg::VERTEX_BITS;
  localparam int BB = skwst_pkg::BONE_BITS;
  localparam int WB = skwst_pkg::WEIGHT_BITS;
  localparam int SC = skwst_pkg::SLOT_COUNT;
  localparam int SB = skwst_pkg::SLOT_BITS;
  localparam int SM = skwst_pkg::SUM_BITS;
  localparam int CB = skwst_pkg::COUNT_BITS;
  localparam int QB = skwst_pkg::QUO_BITS;
  localparam int LN = skwst_pkg::LANES;
  localparam int DB = skwst_pkg::DIV_CNT_BITS;

  typedef enum logic [2:0] {ST_INIT, ST_IDLE, ST_RD, ST_CLR, ST_DIV, ST_DONE} state_t;

  state_t                 state_r;
  logic [VB-1:0]          sweep_r;
  skwst_pkg::item_t       item_r;
  logic [SM-1:0]          sum_r, sum_nxt;
  logic [CB-1:0]          count_r, count_nxt;
  logic [BB-1:0]          recent_r;
  logic [SC*BB-1:0]       rd_bones_r, bones_hold_r, bones_upd;
  logic [SC*WB-1:0]       rd_wts_r, wts_upd;
  logic                   acc_r;
  logic [SB-1:0]          slot_r;
  logic [DB-1:0]          div_cnt_r;
  logic [CB-1:0]          rem_r [LN];
  logic [QB-1:0]          low_r [LN];
  logic [QB-1:0]          quo_r [LN];
  logic [CB-1:0]          dvs_r [LN];
  logic                   zero_r [LN];
  logic                   sat_r [LN];
  logic                   res_valid_r;
  skwst_pkg::res_t        res_r;

  logic [SC*BB-1:0]       bone_mem [skwst_pkg::VERTEX_COUNT];
  logic [SC*WB-1:0]       wt_mem   [skwst_pkg::VERTEX_COUNT];
  logic                   mem_we;
  logic [VB-1:0]          mem_waddr;
  logic [SC*BB-1:0]       mem_wbones;
  logic [SC*WB-1:0]       mem_wwts;

  logic                   hit, do_add, can_count, lane_load, sweep_last;
  logic [SB-1:0]          hit_slot;
  logic [SM:0]            sum_ext;
  logic [skwst_pkg::SLOT_SUM_BITS-1:0] slot_sum;
  logic [SM-1:0]          dvd [LN];
  logic [CB-1:0]          dvs [LN];
  logic [CB:0]            step_trial [LN];
  logic                   step_ge [LN];
  logic [QB-1:0]          lane_val [LN];

  assign init_busy  = (state_r == ST_INIT);
  assign head_pop   = (state_r == ST_IDLE);
  assign res_valid  = res_valid_r;
  assign res        = res_r;
  assign sweep_last = (sweep_r == {VB{1'b1}});

  // first slot with a smaller weight takes the offer
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int m = SC - 1; m >= 0; m--) begin
      if (item_r.weight > rd_wts_r[m*WB +: WB]) begin
        hit      = 1'b1;
        hit_slot = SB'(m);
      end
    end
    bones_upd = rd_bones_r;
    wts_upd   = rd_wts_r;
    bones_upd[hit_slot*BB +: BB] = item_r.bone;
    wts_upd[hit_slot*WB +: WB]   = item_r.weight;
    slot_sum = '0;
    for (int m = 0; m < SC; m++) begin
      slot_sum = slot_sum + skwst_pkg::SLOT_SUM_BITS'(rd_wts_r[m*WB +: WB]);
    end
  end

  assign do_add    = (state_r == ST_RD) && (item_r.op == skwst_pkg::ACT_ADD) && hit;
  assign sum_ext   = {1'b0, sum_r} + (SM+1)'(item_r.weight);
  assign can_count = (count_r != {CB{1'b1}}) && !sum_ext[SM];
  assign sum_nxt   = (do_add && can_count) ? sum_ext[SM-1:0] : sum_r;
  assign count_nxt = (do_add && can_count) ? count_r + CB'(1) : count_r;
  assign lane_load = ((state_r == ST_RD) && (item_r.op != skwst_pkg::ACT_CLEAR)) ||
                     ((state_r == ST_CLR) && sweep_last);

  // divider lanes: one per slot, last one for the running mean
  always_comb begin
    for (int l = 0; l < LN; l++) begin
      if (l < SC) begin
        dvd[l] = SM'({rd_wts_r[l*WB +: WB], {QB{1'b0}}});
        dvs[l] = CB'(slot_sum);
      end else begin
        dvd[l] = sum_nxt;
        dvs[l] = count_nxt;
      end
      step_trial[l] = {rem_r[l], low_r[l][QB-1]};
      step_ge[l]    = step_trial[l] >= {1'b0, dvs_r[l]};
      if (zero_r[l])     lane_val[l] = '0;
      else if (sat_r[l]) lane_val[l] = {QB{1'b1}};
      else               lane_val[l] = quo_r[l];
    end
  end

  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = item_r.vertex;
    mem_wbones = bones_upd;
    mem_wwts   = wts_upd;
    if (state_r == ST_INIT || state_r == ST_CLR) begin
      mem_we     = 1'b1;
      mem_waddr  = sweep_r;
      mem_wbones = '0;
      mem_wwts   = '0;
    end else if (do_add) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bone_mem[mem_waddr] <= mem_wbones;
      wt_mem[mem_waddr]   <= mem_wwts;
    end
    rd_bones_r <= bone_mem[head.item.vertex];
    rd_wts_r   <= wt_mem[head.item.vertex];
  end

  always_ff @(posedge clk) begin
    if (lane_load) begin
      for (int l = 0; l < LN; l++) begin
        dvs_r[l]  <= dvs[l];
        zero_r[l] <= (dvs[l] == '0);
        sat_r[l]  <= dvd[l] >= {dvs[l], {QB{1'b0}}};
        rem_r[l]  <= dvd[l][SM-1:QB];
        low_r[l]  <= dvd[l][QB-1:0];
        quo_r[l]  <= '0;
      end
    end else if (state_r == ST_DIV) begin
      for (int l = 0; l < LN; l++) begin
        rem_r[l] <= step_ge[l] ? CB'(step_trial[l] - {1'b0, dvs_r[l]})
                               : step_trial[l][CB-1:0];
        low_r[l] <= {low_r[l][QB-2:0], 1'b0};
        quo_r[l] <= {quo_r[l][QB-2:0], step_ge[l]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sweep_r     <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      recent_r    <= '0;
      res_valid_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      if (res_ready && state_r != ST_DONE) res_valid_r <= 1'b0;
      unique case (state_r)
        ST_INIT: begin
          sweep_r <= sweep_r + 1'b1;
          if (sweep_last) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (head.valid) begin
            item_r  <= head.item;
            state_r <= ST_RD;
          end
        end
        ST_RD: begin
          sum_r     <= sum_nxt;
          count_r   <= count_nxt;
          acc_r     <= do_add;
          slot_r    <= do_add ? hit_slot : '0;
          div_cnt_r <= '0;
          bones_hold_r <= (item_r.op == skwst_pkg::ACT_READ) ? rd_bones_r : '0;
          if (do_add) recent_r <= item_r.bone;
          if (item_r.op == skwst_pkg::ACT_CLEAR) begin
            sum_r    <= '0;
            count_r  <= '0;
            recent_r <= '0;
            sweep_r  <= '0;
            state_r  <= ST_CLR;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_CLR: begin
          sweep_r <= sweep_r + 1'b1;
          if (sweep_last) state_r <= ST_DIV;
        end
        ST_DIV: begin
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == DB'(QB - 1)) state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!res_valid_r || res_ready) begin
            res_valid_r        <= 1'b1;
            res_r.accepted     <= acc_r;
            res_r.slot         <= slot_r;
            res_r.bones        <= bones_hold_r;
            for (int m = 0; m < SC; m++) begin
              res_r.norms[m] <= (item_r.op == skwst_pkg::ACT_READ) ? lane_val[m] : '0;
            end
            res_r.mean         <= lane_val[SC];
            res_r.last_bone    <= recent_r;
            state_r            <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> src/skwst_checker.sv
`timescale 1ns / 1ps
module skwst_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_action,
  input logic [11:0] in_vertex,
  input logic [7:0]  in_bone,
  input logic [15:0] in_weight,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_accepted,
  input logic [1:0]  out_slot,
  input logic [7:0]  out_bone_a,
  input logic [7:0]  out_bone_b,
  input logic [7:0]  out_bone_c,
  input logic [7:0]  out_bone_d,
  input logic [15:0] out_norm_weight_a,
  input logic [15:0] out_norm_weight_b,
  input logic [15:0] out_norm_weight_c,
  input logic [15:0] out_norm_weight_d,
  input logic [15:0] out_mean_weight,
  input logic [7:0]  out_last_bone
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_action) && $stable(in_vertex) &&
    $stable(in_bone) && $stable(in_weight))
    else $error("stalled input transaction changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mean_weight) &&
    $stable(out_last_bone) && $stable(out_accepted))
    else $error("stalled result changed");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_slot == 2'd0)
    else $error("slot set without accepted add");

  a_add_no_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_norm_weight_a == 16'd0 && out_norm_weight_b == 16'd0 &&
    out_norm_weight_c == 16'd0 && out_norm_weight_d == 16'd0 && out_bone_a == 8'd0 &&
    out_bone_b == 8'd0 && out_bone_c == 8'd0 && out_bone_d == 8'd0)
    else $error("read fields set on add result");

  a_init_block: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("input taken during clearing pass");

endmodule

bind skin_weight_slot_table_top skwst_checker u_skwst_checker (.*);
